/* rtl/lpr_pkg.sv */
// shared types and constants of the line pixel rasterizer
// used by lpr_front, lpr_queue, lpr_back and line_pixel_rasterizer; no dependencies
package lpr_pkg;

  localparam int COORD_W     = 12;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // command codes carried in s_tuser
  localparam logic CMD_ADVANCE = 1'b0;
  localparam logic CMD_START   = 1'b1;

  typedef enum logic [1:0] {
    KIND_XMAJOR = 2'd0,
    KIND_YMAJOR = 2'd1,
    KIND_VERT   = 2'd2,
    KIND_HORZ   = 2'd3
  } lpr_kind_t;

  // one classified item between front and back
  typedef struct packed {
    logic                       start;
    lpr_kind_t                  kind;
    logic [1:0]                 gray;
    logic                       dotted;
    logic                       x_neg;
    logic                       y_neg;
    logic signed [COORD_W-1:0]  cur_x;
    logic signed [COORD_W-1:0]  cur_y;
    logic signed [COORD_W-1:0]  stop_x;
    logic signed [COORD_W-1:0]  stop_y;
    logic signed [14:0]         decision;
    logic signed [13:0]         step_lo;  // added while the decision term is negative
    logic signed [13:0]         step_hi;  // added otherwise, minor axis also steps
  } lpr_entry_t;

endpackage

/* rtl/line_pixel_rasterizer.sv */
// an advance item runs through the input register, the queue and the output register
// one item per cycle; a start item gives no output, an advance one pixel while a line is active
// the back end stepper sets the rate: one queue entry per cycle, held while m_tready stalls
// reset: synchronous active-high rst clears dotted_pattern, the queue and the active line
// top level, instantiates lpr_front, lpr_queue and lpr_back; depends on lpr_pkg
module line_pixel_rasterizer #(
  parameter int DISPLAY_WIDTH  = 256,
  parameter int DISPLAY_HEIGHT = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // x_start[11:0], y_start[23:12], x_end[35:24], y_end[47:36], gray_level[49:48], zero pad
  input  logic [lpr_pkg::IN_TDATA_W-1:0]      s_tdata,
  // cmd
  input  logic                                s_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_data,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // pixel_x[11:0], pixel_y[23:12], pixel_gray[25:24], zero pad
  output logic [lpr_pkg::OUT_TDATA_W-1:0]     m_tdata,
  // on_screen
  output logic                                m_tuser,
  // last_pixel
  output logic                                m_tlast
);

  logic                 q_wr, q_full, q_rd, q_valid;
  lpr_pkg::lpr_entry_t  q_wdata, q_rdata;

  // classification front end
  lpr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_wr      (q_wr),
    .q_full    (q_full),
    .q_wdata   (q_wdata)
  );

  // decoupling queue
  lpr_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (q_wr),
    .wdata  (q_wdata),
    .full   (q_full),
    .rd     (q_rd),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  // pixel stepper
  lpr_back #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_rdata  (q_rdata),
    .q_rd     (q_rd),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

/* rtl/lpr_front.sv */
// front end: accepts items, holds the dotted_pattern register, classifies start items
// depends on lpr_pkg
module lpr_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [lpr_pkg::IN_TDATA_W-1:0]      s_tdata,
  input  logic                                s_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_data,
  output logic                                q_wr,
  input  logic                                q_full,
  output lpr_pkg::lpr_entry_t                 q_wdata
);

  logic                     dotted_pattern;
  logic                     r_valid;
  logic                     r_cmd;
  logic signed [11:0]       r_x0, r_y0, r_x1, r_y1;
  logic [1:0]               r_gray;
  logic                     r_dotted;
  logic signed [12:0]       r_dx, r_dy;

  logic [12:0]              abs_dx13, abs_dy13;
  logic [11:0]              abs_dx, abs_dy;
  logic                     x_major;
  logic signed [13:0]       twice_dx, twice_dy;
  lpr_pkg::lpr_entry_t      ent;

  assign cfg_ready = 1'b1;
  assign s_tready  = !r_valid || !q_full;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      dotted_pattern <= 1'b0;
    end else if (cfg_valid) begin
      dotted_pattern <= cfg_data;
    end
  end

  // input register with endpoint differences
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (s_tready) begin
      r_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      r_cmd    <= s_tuser;
      r_x0     <= s_tdata[11:0];
      r_y0     <= s_tdata[23:12];
      r_x1     <= s_tdata[35:24];
      r_y1     <= s_tdata[47:36];
      r_gray   <= s_tdata[49:48];
      r_dotted <= dotted_pattern;
      r_dx     <= $signed({s_tdata[35], s_tdata[35:24]}) - $signed({s_tdata[11], s_tdata[11:0]});
      r_dy     <= $signed({s_tdata[47], s_tdata[47:36]}) - $signed({s_tdata[23], s_tdata[23:12]});
    end
  end

  // magnitudes and major axis
  assign abs_dx13 = r_dx[12] ? 13'(-r_dx) : 13'(r_dx);
  assign abs_dy13 = r_dy[12] ? 13'(-r_dy) : 13'(r_dy);
  assign abs_dx   = abs_dx13[11:0];
  assign abs_dy   = abs_dy13[11:0];
  assign x_major  = abs_dx >= abs_dy;
  assign twice_dx = $signed({1'b0, abs_dx, 1'b0});
  assign twice_dy = $signed({1'b0, abs_dy, 1'b0});

  // classify the line and build the queue entry
  always_comb begin
    ent          = '0;
    ent.start    = (r_cmd == lpr_pkg::CMD_START);
    ent.gray     = r_gray;
    ent.dotted   = r_dotted;
    ent.x_neg    = r_dx[12];
    ent.y_neg    = r_dy[12];
    ent.cur_x    = r_x0;
    ent.cur_y    = r_y0;
    ent.stop_x   = r_x1;
    ent.stop_y   = r_y1;
    priority if (r_dx == 13'sd0) begin
      ent.kind   = lpr_pkg::KIND_VERT;
      ent.stop_x = r_x0;
      ent.cur_y  = r_dy[12] ? r_y1 : r_y0;
      ent.stop_y = r_dy[12] ? r_y0 : r_y1;
    end else if (r_dy == 13'sd0) begin
      ent.kind   = lpr_pkg::KIND_HORZ;
      ent.stop_y = r_y0;
      ent.cur_x  = r_dx[12] ? r_x1 : r_x0;
      ent.stop_x = r_dx[12] ? r_x0 : r_x1;
    end else if (x_major) begin
      ent.kind     = lpr_pkg::KIND_XMAJOR;
      ent.decision = $signed({1'b0, twice_dy}) - $signed({3'b0, abs_dx});
      ent.step_lo  = twice_dy;
      ent.step_hi  = twice_dy - twice_dx;
    end else begin
      ent.kind     = lpr_pkg::KIND_YMAJOR;
      ent.decision = $signed({1'b0, twice_dx}) - $signed({3'b0, abs_dy});
      ent.step_lo  = twice_dx;
      ent.step_hi  = twice_dx - twice_dy;
    end
  end

  assign q_wr    = r_valid && !q_full;
  assign q_wdata = ent;

endmodule

/* rtl/lpr_queue.sv */
// short queue of classified items between front end and pixel stepper
// depends on lpr_pkg
module lpr_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr,
  input  lpr_pkg::lpr_entry_t  wdata,
  output logic                 full,
  input  logic                 rd,
  output logic                 rvalid,
  output lpr_pkg::lpr_entry_t  rdata
);

  lpr_pkg::lpr_entry_t          slots [lpr_pkg::QUEUE_DEPTH];
  logic [lpr_pkg::QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [lpr_pkg::QPTR_W:0]     count;

  assign full   = (count == (lpr_pkg::QPTR_W+1)'(lpr_pkg::QUEUE_DEPTH));
  assign rvalid = (count != '0);
  assign rdata  = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (lpr_pkg::QPTR_W+1)'(wr) - (lpr_pkg::QPTR_W+1)'(rd);
    end
  end

endmodule

/* rtl/lpr_back.sv */
// back end: line state, bresenham stepper and output register
// depends on lpr_pkg
module lpr_back #(
  parameter int DISPLAY_WIDTH  = 256,
  parameter int DISPLAY_HEIGHT = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_valid,
  input  lpr_pkg::lpr_entry_t                 q_rdata,
  output logic                                q_rd,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [lpr_pkg::OUT_TDATA_W-1:0]     m_tdata,
  output logic                                m_tuser,
  output logic                                m_tlast
);

  localparam logic [11:0] WIDTH_L  = 12'(DISPLAY_WIDTH);
  localparam logic [11:0] HEIGHT_L = 12'(DISPLAY_HEIGHT);

  logic                 active;
  lpr_pkg::lpr_kind_t   kind;
  logic [1:0]           gray;
  logic                 dotted, x_neg, y_neg;
  logic signed [11:0]   cur_x, cur_y, stop_x, stop_y;
  logic signed [14:0]   decision;
  logic signed [13:0]   step_lo, step_hi;

  logic signed [11:0]   cur_x_next, cur_y_next;
  logic signed [14:0]   decision_next;
  logic                 last;
  logic signed [12:0]   step_ax;
  logic signed [12:0]   diff_x, diff_y;
  logic signed [11:0]   sx, sy;
  logic signed [14:0]   dec_sum;
  logic                 on_screen;
  logic                 out_free, emit;

  logic signed [11:0]   px, py;
  logic [1:0]           pg;
  logic                 pon, plast;

  // handshake between queue, line state and output register
  assign out_free = !m_tvalid || m_tready;
  assign emit     = q_valid && !q_rdata.start && active && out_free;
  assign q_rd     = q_valid && (q_rdata.start || !active || out_free);

  // pixel visibility
  assign on_screen = !cur_x[11] && ({1'b0, cur_x[10:0]} < WIDTH_L) &&
                     !cur_y[11] && ({1'b0, cur_y[10:0]} < HEIGHT_L);

  // one step of the line
  always_comb begin
    step_ax       = dotted ? 13'sd2 : 13'sd1;
    diff_x        = $signed({stop_x[11], stop_x}) - $signed({cur_x[11], cur_x});
    diff_y        = $signed({stop_y[11], stop_y}) - $signed({cur_y[11], cur_y});
    sx            = x_neg ? -12'sd1 : 12'sd1;
    sy            = y_neg ? -12'sd1 : 12'sd1;
    dec_sum       = decision[14] ? (decision + 15'(step_lo)) : (decision + 15'(step_hi));
    cur_x_next    = cur_x;
    cur_y_next    = cur_y;
    decision_next = decision;
    last          = 1'b0;
    unique case (kind)
      lpr_pkg::KIND_VERT: begin
        last       = diff_y < step_ax;
        cur_y_next = cur_y + step_ax[11:0];
      end
      lpr_pkg::KIND_HORZ: begin
        last       = diff_x < step_ax;
        cur_x_next = cur_x + step_ax[11:0];
      end
      lpr_pkg::KIND_XMAJOR: begin
        last = (cur_x == stop_x);
        if (!last) begin
          cur_x_next    = cur_x + sx;
          decision_next = dec_sum;
          if (!decision[14]) begin
            cur_y_next = cur_y + sy;
          end
        end
      end
      lpr_pkg::KIND_YMAJOR: begin
        last = (cur_y == stop_y);
        if (!last) begin
          cur_y_next    = cur_y + sy;
          decision_next = dec_sum;
          if (!decision[14]) begin
            cur_x_next = cur_x + sx;
          end
        end
      end
      default: begin
        last = 1'b1;
      end
    endcase
  end

  // line active flag
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (q_rd) begin
      if (q_rdata.start) begin
        active <= 1'b1;
      end else if (emit && last) begin
        active <= 1'b0;
      end
    end
  end

  // line state
  always_ff @(posedge clk) begin
    if (q_rd && q_rdata.start) begin
      kind     <= q_rdata.kind;
      gray     <= q_rdata.gray;
      dotted   <= q_rdata.dotted;
      x_neg    <= q_rdata.x_neg;
      y_neg    <= q_rdata.y_neg;
      cur_x    <= q_rdata.cur_x;
      cur_y    <= q_rdata.cur_y;
      stop_x   <= q_rdata.stop_x;
      stop_y   <= q_rdata.stop_y;
      decision <= q_rdata.decision;
      step_lo  <= q_rdata.step_lo;
      step_hi  <= q_rdata.step_hi;
    end else if (emit) begin
      cur_x    <= cur_x_next;
      cur_y    <= cur_y_next;
      decision <= decision_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      px    <= cur_x;
      py    <= cur_y;
      pg    <= gray;
      pon   <= on_screen;
      plast <= last;
    end
  end

  assign m_tdata = {6'b0, pg, py, px};
  assign m_tuser = pon;
  assign m_tlast = plast;

endmodule

/* rtl/lpr_checker.sv */
// port-level checks of the line pixel rasterizer, bound to the top level
// depends on line_pixel_rasterizer and lpr_pkg
module lpr_checker #(
  parameter int DISPLAY_WIDTH  = 256,
  parameter int DISPLAY_HEIGHT = 64
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tready,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [lpr_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input logic                               m_tuser,
  input logic                               m_tlast
);

  localparam logic [11:0] WIDTH_L  = 12'(DISPLAY_WIDTH);
  localparam logic [11:0] HEIGHT_L = 12'(DISPLAY_HEIGHT);

  logic in_area;

  // pixel position inside the display
  assign in_area = !m_tdata[11] && ({1'b0, m_tdata[10:0]} < WIDTH_L) &&
                   !m_tdata[23] && ({1'b0, m_tdata[22:12]} < HEIGHT_L);

  // no pixel right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("pixel item shown right after reset");

  // input side free right after reset
  a_reset_ready: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready after reset");

  // stalled pixel item holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                              $stable(m_tlast))
    else $error("stalled pixel item changed");

  // visibility flag agrees with position
  a_on_screen: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == in_area))
    else $error("on_screen flag does not match pixel position");

endmodule

bind line_pixel_rasterizer lpr_checker #(
  .DISPLAY_WIDTH  (DISPLAY_WIDTH),
  .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
) u_lpr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
